// ----- design/rrqe_pkg.sv -----
package rrqe_pkg;

  localparam int unsigned IdW = 7;

  localparam logic [IdW-1:0] START_RESET = 7'd64;

  localparam logic OP_SERVE    = 1'b0;
  localparam logic OP_EXPEDITE = 1'b1;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic           serve;
    logic           expedite;
    logic           reload;
    logic [IdW-1:0] load_count;
    logic [IdW-1:0] head;
    logic [IdW-1:0] id;
  } rrqe_ctrl_t;

endpackage

// ----- design/rrqe_cell.sv -----
module rrqe_cell
  import rrqe_pkg::*;
#(
  parameter int IDX         = 0,
  parameter int RESET_COUNT = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rrqe_ctrl_t     ctrl_i,
  input  logic [IdW-1:0] left_value_i,
  input  logic           left_valid_i,
  input  logic [IdW-1:0] right_value_i,
  input  logic           right_valid_i,
  input  logic           match_i,
  input  logic           found_i,
  output logic [IdW-1:0] value_o,
  output logic           valid_o,
  output logic           match_o
);

  localparam logic           ResetValid = (IDX < RESET_COUNT);
  localparam logic [IdW-1:0] ResetValue = ResetValid ? IdW'(IDX + 1) : '0;

  logic [IdW-1:0] value_q, value_d;
  logic           valid_q, valid_d;
  logic           shift_in;

  assign match_o = match_i | (valid_q & (value_q == ctrl_i.id));

  // cells up to the matched one, or up to the first empty one on insert, take their left neighbor
  assign shift_in = ~match_i & (found_i | left_valid_i);

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    if (ctrl_i.reload) begin
      valid_d = (IDX < int'(ctrl_i.load_count));
      value_d = valid_d ? IdW'(IDX + 1) : '0;
    end else if (ctrl_i.serve && valid_q) begin
      // the last occupied cell receives the old head
      value_d = right_valid_i ? right_value_i : ctrl_i.head;
    end else if (ctrl_i.expedite && shift_in) begin
      value_d = left_value_i;
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= ResetValue;
      valid_q <= ResetValid;
    end else begin
      value_q <= value_d;
      valid_q <= valid_d;
    end
  end

  assign value_o = value_q;
  assign valid_o = valid_q;

endmodule

// ----- design/round_robin_queue_with_expedite.sv -----
// channel | direction | handshake               | payload
// in      | input     | in_valid_i / in_stall_o | opcode_i, req_id_i
// out     | output    | out_valid_o / out_stall_i | served_id_o
// cfg     | input     | cfg_valid_i / cfg_ready_o | start_count_i
//
// one transaction per cycle while in_stall_o is low: every cell of the list updates in
// the cycle the item is taken, the id search ripples along the row of cells
// a serve result is held in an output register; input stalls only while it waits
// reset loads ids 1..min(64, MAX_IDS); a config write reloads the list at once
module round_robin_queue_with_expedite
  import rrqe_pkg::*;
#(
  parameter int MAX_IDS = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic           opcode_i,
  input  logic [IdW-1:0] req_id_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [IdW-1:0] served_id_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [IdW-1:0] start_count_i
);

  localparam int ResetCount = (int'(START_RESET) > MAX_IDS) ? MAX_IDS : int'(START_RESET);

  logic [IdW-1:0] val_w [MAX_IDS];
  logic           vld_w [MAX_IDS];
  logic           mch_w [MAX_IDS];

  rrqe_ctrl_t     ctrl;
  logic           in_fire;
  logic           found;
  logic           id_ok;
  logic           out_valid_q, out_valid_d;
  logic [IdW-1:0] served_id_q, served_id_d;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_fire     = in_valid_i & ~in_stall_o;

  assign found = mch_w[MAX_IDS-1];
  assign id_ok = (req_id_i != '0) && (int'(req_id_i) <= MAX_IDS);

  always_comb begin
    ctrl.reload     = cfg_valid_i & cfg_ready_o;
    ctrl.load_count = (int'(start_count_i) > MAX_IDS) ? IdW'(MAX_IDS) : start_count_i;
    ctrl.serve      = in_fire & (opcode_i == OP_SERVE);
    // a full list with no match cannot grow
    ctrl.expedite   = in_fire & (opcode_i == OP_EXPEDITE) & id_ok &
                      (found | ~vld_w[MAX_IDS-1]);
    ctrl.head       = val_w[0];
    ctrl.id         = req_id_i;
  end

  for (genvar i = 0; i < MAX_IDS; i++) begin : g_cell
    logic [IdW-1:0] left_value, right_value;
    logic           left_valid, right_valid, match_in;

    if (i == 0) begin : g_first
      // the expedited id enters from the left of the head cell
      assign left_value = req_id_i;
      assign left_valid = 1'b1;
      assign match_in   = 1'b0;
    end else begin : g_inner
      assign left_value = val_w[i-1];
      assign left_valid = vld_w[i-1];
      assign match_in   = mch_w[i-1];
    end

    if (i == MAX_IDS - 1) begin : g_last
      assign right_value = '0;
      assign right_valid = 1'b0;
    end else begin : g_mid
      assign right_value = val_w[i+1];
      assign right_valid = vld_w[i+1];
    end

    rrqe_cell #(
      .IDX        (i),
      .RESET_COUNT(ResetCount)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .left_value_i (left_value),
      .left_valid_i (left_valid),
      .right_value_i(right_value),
      .right_valid_i(right_valid),
      .match_i      (match_in),
      .found_i      (found),
      .value_o      (val_w[i]),
      .valid_o      (vld_w[i]),
      .match_o      (mch_w[i])
    );
  end

  always_comb begin
    out_valid_d = out_valid_q;
    served_id_d = served_id_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (ctrl.serve) begin
      out_valid_d = 1'b1;
      served_id_d = vld_w[0] ? val_w[0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    served_id_q <= served_id_d;
  end

  assign out_valid_o = out_valid_q;
  assign served_id_o = served_id_q;

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rrqe_pkg::*;

  localparam int MaxIds = 64;
  localparam int NumDirected = 26;
  localparam int ItemsPerPhase = 146;

  typedef logic [IdW-1:0] id_t;

  // one row of the directed part: either a start_count write or a request
  typedef struct packed {
    logic is_cfg;
    logic op;
    id_t  val;
    logic has_exp;
    id_t  exp_id;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic opcode_i = OP_SERVE;
  id_t  req_id_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  id_t  served_id_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  id_t  start_count_i = START_RESET;

  // travels with the request payload: a hand-typed expectation for the row
  logic typed_has = 1'b0;
  id_t  typed_val = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // predictor state
  id_t rr_order [MaxIds];
  int  rr_len;

  id_t served_q [$];
  int  mismatches = 0;
  int  served_cnt = 0;
  int  empty_serve_cnt = 0;
  int  expedite_cnt = 0;
  int  ignored_cnt = 0;
  int  cfg_cnt = 0;

  dir_row_t dir_rows [NumDirected];

  round_robin_queue_with_expedite #(
    .MAX_IDS(MaxIds)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .req_id_i     (req_id_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .served_id_o  (served_id_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .start_count_i(start_count_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void reload_order(id_t count);
    int n;
    n = (count > MaxIds) ? MaxIds : int'(count);
    for (int i = 0; i < MaxIds; i++) rr_order[i] = (i < n) ? id_t'(i + 1) : '0;
    rr_len = n;
  endfunction

  // returns 1 when the request produces a served id
  function automatic bit apply_request(logic op, id_t id, output id_t served);
    int  pos;
    id_t head;
    served = '0;
    if (op == OP_SERVE) begin
      if (rr_len == 0) return 1'b1;
      head = rr_order[0];
      for (int i = 1; i < rr_len; i++) rr_order[i-1] = rr_order[i];
      rr_order[rr_len-1] = head;
      served = head;
      return 1'b1;
    end
    if (id == 0 || id > MaxIds) return 1'b0;
    pos = rr_len;
    for (int i = 0; i < rr_len; i++) begin
      if (rr_order[i] == id) begin
        pos = i;
        break;
      end
    end
    // not in the list: it joins at the head and the list grows
    if (pos == rr_len) begin
      if (rr_len >= MaxIds) return 1'b0;
      rr_len++;
    end
    for (int i = pos; i > 0; i--) rr_order[i] = rr_order[i-1];
    rr_order[0] = id;
    return 1'b0;
  endfunction

  function automatic void flag_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("ERROR at %0t: %s", $realtime, msg);
  endfunction

  always @(posedge clk_i) out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);

  always @(posedge clk_i) begin : scoreboard
    id_t pred;
    id_t want;
    bit  has;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        reload_order(start_count_i);
        cfg_cnt++;
      end
      if (in_valid_i && !in_stall_o) begin
        has = apply_request(opcode_i, req_id_i, pred);
        if (has) begin
          served_q.insert(served_q.size(), typed_has ? typed_val : pred);
          if (pred == 0) empty_serve_cnt++;
        end else if (req_id_i != 0 && req_id_i <= MaxIds) begin
          expedite_cnt++;
        end else begin
          ignored_cnt++;
        end
      end
      if (out_valid_o && !out_stall_i) begin
        if (served_q.size() == 0) begin
          flag_error($sformatf("served_id %0d with no transaction pending", served_id_o));
        end else begin
          want = served_q[0];
          served_q.delete(0);
          served_cnt++;
          if (served_id_o !== want)
            flag_error($sformatf("served_id expected %0d, got %0d", want, served_id_o));
        end
      end
    end
  end

  task automatic send_request(logic op, id_t id, logic has_exp, id_t exp_id);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    req_id_i   <= id;
    typed_has  <= has_exp;
    typed_val  <= exp_id;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // only while idle: drain results, then let a trailing expedite settle
  task automatic write_start_count(id_t value);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (served_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i   <= 1'b1;
    start_count_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    int  sched [12];
    int  counted;
    int  r;
    id_t id;
    sched = '{1, -1, 64, 0, 127, -1, 2, -1, 0, 64, -1, 127};
    dir_rows = '{
      '{1'b0, OP_SERVE,    7'd0,   1'b1, 7'd1},
      '{1'b0, OP_SERVE,    7'd0,   1'b1, 7'd2},
      '{1'b0, OP_EXPEDITE, 7'd64,  1'b0, 7'd0},
      '{1'b0, OP_SERVE,    7'd0,   1'b1, 7'd64},
      '{1'b0, OP_EXPEDITE, 7'd0,   1'b0, 7'd0},
      '{1'b0, OP_EXPEDITE, 7'd127, 1'b0, 7'd0},
      '{1'b0, OP_EXPEDITE, 7'd65,  1'b0, 7'd0},
      '{1'b0, OP_SERVE,    7'd0,   1'b1, 7'd3},
      '{1'b0, OP_EXPEDITE, 7'd4,   1'b0, 7'd0},
      '{1'b0, OP_EXPEDITE, 7'd4,   1'b0, 7'd0},
      '{1'b0, OP_SERVE,    7'd0,   1'b0, 7'd0},
      '{1'b1, OP_SERVE,    7'd0,   1'b0, 7'd0},
      '{1'b0, OP_SERVE,    7'd0,   1'b1, 7'd0},
      '{1'b0, OP_EXPEDITE, 7'd5,   1'b0, 7'd0},
      '{1'b0, OP_SERVE,    7'd0,   1'b1, 7'd5},
      '{1'b0, OP_SERVE,    7'd0,   1'b1, 7'd5},
      '{1'b0, OP_EXPEDITE, 7'd1,   1'b0, 7'd0},
      '{1'b0, OP_SERVE,    7'd0,   1'b0, 7'd0},
      '{1'b1, OP_SERVE,    7'd127, 1'b0, 7'd0},
      '{1'b0, OP_SERVE,    7'd0,   1'b1, 7'd1},
      '{1'b0, OP_EXPEDITE, 7'd64,  1'b0, 7'd0},
      '{1'b0, OP_SERVE,    7'd0,   1'b1, 7'd64},
      '{1'b1, OP_SERVE,    7'd1,   1'b0, 7'd0},
      '{1'b0, OP_SERVE,    7'd0,   1'b1, 7'd1},
      '{1'b0, OP_EXPEDITE, 7'd63,  1'b0, 7'd0},
      '{1'b0, OP_SERVE,    7'd0,   1'b0, 7'd0}
    };
    reload_order(START_RESET);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    send_idle_pct  = 6;
    recv_stall_pct = 68;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_start_count(dir_rows[i].val);
      else send_request(dir_rows[i].op, dir_rows[i].val, dir_rows[i].has_exp,
                        dir_rows[i].exp_id);
    end

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct  = (mode == 0) ? 6 : (mode == 1) ? 68 : 0;
      recv_stall_pct = (mode == 0) ? 68 : (mode == 1) ? 6 : 0;
      for (int ph = 0; ph < 4; ph++) begin
        r = sched[mode*4 + ph];
        write_start_count((r < 0) ? id_t'($urandom_range(3, 63)) : id_t'(r));
        counted = 0;
        while (counted < ItemsPerPhase) begin
          r = $urandom_range(0, 99);
          if (r < 55) begin
            send_request(OP_SERVE, id_t'($urandom), 1'b0, '0);
            counted++;
          end else if (r < 92) begin
            send_request(OP_EXPEDITE, id_t'($urandom_range(1, MaxIds)), 1'b0, '0);
            counted++;
          end else begin
            // out-of-range ids are dropped by the block
            id = (r < 95) ? '0 : id_t'($urandom_range(MaxIds + 1, 127));
            send_request(OP_EXPEDITE, id, 1'b0, '0);
            counted++;
          end
        end
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (served_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("covered %0d served ids (%0d from an empty list), %0d expedites, %0d dropped ids",
             served_cnt, empty_serve_cnt, expedite_cnt, ignored_cnt);
    $display("across %0d start_count writes and three stall patterns, %0d mismatches",
             cfg_cnt, mismatches);
    if (mismatches == 0 && served_q.size() == 0) begin
      $display("round_robin_queue_with_expedite regression: pass");
    end else begin
      $display("round_robin_queue_with_expedite regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("timeout waiting for transactions");
    $display("round_robin_queue_with_expedite regression: fail");
    $finish;
  end

endmodule
